// ===== src/nsht_pkg.sv =====
// Shared constants and types of the node shape hit test.
// Used by the channel interfaces, the pipeline and the top level.
`timescale 1ns / 1ps

package nsht_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned MIN_BAND_RESET = 48;
  localparam logic        FRAME_EN_RESET = 1'b1;
  localparam int unsigned APB_ADDR_BITS  = 3;

  typedef enum logic [2:0] {
    SHAPE_CIRCLE  = 3'd0,
    SHAPE_ELLIPSE = 3'd1,
    SHAPE_BOX     = 3'd2,
    SHAPE_RHOMBUS = 3'd3,
    SHAPE_NONE    = 3'd4
  } shape_kind_e;

  typedef enum logic {
    REG_MIN_BAND = 1'b0,
    REG_FRAME_EN = 1'b1
  } reg_idx_e;

endpackage

// ===== src/nsht_if.sv =====
// Request and result channels of the node shape hit test.
// Depends on nsht_pkg for the default coordinate width.
`timescale 1ns / 1ps

interface nsht_query_if #(
  parameter int unsigned COORD_BITS = nsht_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] half_width;
  logic        [COORD_BITS-2:0] half_height;
  logic        [COORD_BITS-2:0] border;
  logic        [2:0]            shape_kind;

  modport source (
    output valid, query_x, query_y, center_x, center_y,
    output half_width, half_height, border, shape_kind,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, center_x, center_y,
    input  half_width, half_height, border, shape_kind,
    output ready
  );
endinterface

interface nsht_result_if;
  logic valid;
  logic ready;
  logic hit;
  logic on_frame;

  modport source (output valid, hit, on_frame, input ready);
  modport sink (input valid, hit, on_frame, output ready);
endinterface

// ===== src/nsht_pipe.sv =====
// Six-stage hit test pipeline: offsets, radii and band, products, compares.
// Depends on nsht_pkg and the channel interfaces in nsht_if.sv.
`timescale 1ns / 1ps

module nsht_pipe #(
  parameter int unsigned COORD_BITS = nsht_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS-2:0] min_band_i,
  input  logic                  frame_en_i,
  nsht_query_if.sink            req_i,
  nsht_result_if.source         rsp_o
);

  localparam int unsigned W   = COORD_BITS;
  localparam int unsigned RW  = COORD_BITS - 1;
  localparam int unsigned PW  = 2 * COORD_BITS;
  localparam int unsigned EW  = 2 * COORD_BITS - 1;
  localparam int unsigned RHW = 2 * COORD_BITS + 2;
  localparam int unsigned RSW = 2 * COORD_BITS + 4;
  localparam int unsigned QW  = 4 * COORD_BITS - 2;
  localparam int unsigned LW  = 4 * COORD_BITS + 5;
  localparam int unsigned NST = 6;

  // ---------------- stage control ----------------
  logic [NST:1]   vld_q, vld_d;
  logic [NST+1:1] stg_en;

  always_comb begin
    stg_en[NST+1] = rsp_o.ready;
    for (int k = NST; k >= 1; k--) begin
      stg_en[k] = !vld_q[k] || stg_en[k+1];
    end
    vld_d[1] = stg_en[1] ? req_i.valid : vld_q[1];
    for (int k = 2; k <= NST; k++) begin
      vld_d[k] = stg_en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign req_i.ready = stg_en[1];

  // ---------------- stage 1: offsets, band ----------------
  logic signed [W:0]    dx_c, dy_c;
  logic        [W-1:0]  ax_c, ay_c;
  logic        [RW-1:0] band_c;

  assign dx_c   = (W+1)'(req_i.query_x) - (W+1)'(req_i.center_x);
  assign dy_c   = (W+1)'(req_i.query_y) - (W+1)'(req_i.center_y);
  assign ax_c   = dx_c[W] ? W'(-dx_c) : W'(dx_c);
  assign ay_c   = dy_c[W] ? W'(-dy_c) : W'(dy_c);
  assign band_c = (req_i.border < min_band_i) ? min_band_i : req_i.border;

  logic signed [W:0]    s1_dx_q, s1_dy_q;
  logic        [W-1:0]  s1_ax_q, s1_ay_q;
  logic        [RW-1:0] s1_r1_q, s1_r2_q, s1_d_q;
  logic        [2:0]    s1_kind_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[1]) begin
      s1_dx_q   <= dx_c;
      s1_dy_q   <= dy_c;
      s1_ax_q   <= ax_c;
      s1_ay_q   <= ay_c;
      s1_r1_q   <= req_i.half_width;
      s1_r2_q   <= req_i.half_height;
      s1_d_q    <= band_c;
      s1_kind_q <= req_i.shape_kind;
    end
  end

  // ---------------- stage 2: outer/inner radii, first products ----------------
  logic signed [W:0]    rp1_c, rp2_c, rm1_c, rm2_c;
  logic        [RW-1:0] rm1_mag_c;
  logic        [EW-1:0] ep_c [3];
  logic        [PW-1:0] dx2_c, dy2_c;

  always_comb begin
    rp1_c     = $signed({2'b00, s1_r1_q}) + $signed({2'b00, s1_d_q});
    rp2_c     = $signed({2'b00, s1_r2_q}) + $signed({2'b00, s1_d_q});
    rm1_c     = $signed({2'b00, s1_r1_q}) - $signed({2'b00, s1_d_q});
    rm2_c     = $signed({2'b00, s1_r2_q}) - $signed({2'b00, s1_d_q});
    rm1_mag_c = (s1_r1_q > s1_d_q) ? (s1_r1_q - s1_d_q) : (s1_d_q - s1_r1_q);
    // ellipse terms: (|dx|*r2)^2 + (|dy|*r1)^2 against (r1*r2)^2
    ep_c[0]   = EW'(s1_ax_q) * EW'(s1_r2_q);
    ep_c[1]   = EW'(s1_ay_q) * EW'(s1_r1_q);
    ep_c[2]   = EW'(s1_r1_q) * EW'(s1_r2_q);
    dx2_c     = PW'(s1_ax_q) * PW'(s1_ax_q);
    dy2_c     = PW'(s1_ay_q) * PW'(s1_ay_q);
  end

  logic signed [W:0]    s2_dx_q, s2_dy_q;
  logic signed [W:0]    s2_rp1_q, s2_rp2_q, s2_rm1_q, s2_rm2_q;
  logic        [W-1:0]  s2_ax_q, s2_ay_q;
  logic        [RW-1:0] s2_rm1_mag_q;
  logic                 s2_rm1_le0_q;
  logic        [EW-1:0] s2_ep_q [3];
  logic        [PW-1:0] s2_dx2_q, s2_dy2_q;
  logic        [2:0]    s2_kind_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[2]) begin
      s2_dx_q      <= s1_dx_q;
      s2_dy_q      <= s1_dy_q;
      s2_rp1_q     <= rp1_c;
      s2_rp2_q     <= rp2_c;
      s2_rm1_q     <= rm1_c;
      s2_rm2_q     <= rm2_c;
      s2_ax_q      <= s1_ax_q;
      s2_ay_q      <= s1_ay_q;
      s2_rm1_mag_q <= rm1_mag_c;
      s2_rm1_le0_q <= (s1_r1_q <= s1_d_q);
      s2_ep_q      <= ep_c;
      s2_dx2_q     <= dx2_c;
      s2_dy2_q     <= dy2_c;
      s2_kind_q    <= s1_kind_q;
    end
  end

  // ---------------- stage 3: squares, edge products, box compares ----------------
  logic        [PW:0]    dist2_c;
  logic        [PW-1:0]  cp2_c;
  logic        [PW-3:0]  cm2_c;
  logic                  box_hit_c, box_frm_c;
  logic signed [RHW-1:0] po_c, ao_c, bo_c, pi_c, ai_c, bi_c;
  logic        [PW-1:0]  ll_c [3];
  logic        [PW-2:0]  hl_c [3];
  logic        [PW-3:0]  hh_c [3];

  always_comb begin
    dist2_c   = (PW+1)'(s2_dx2_q) + (PW+1)'(s2_dy2_q);
    cp2_c     = PW'(s2_rp1_q[W-1:0]) * PW'(s2_rp1_q[W-1:0]);
    cm2_c     = (PW-2)'(s2_rm1_mag_q) * (PW-2)'(s2_rm1_mag_q);
    box_hit_c = (s2_ax_q < s2_rp1_q[W-1:0]) && (s2_ay_q < s2_rp2_q[W-1:0]);
    box_frm_c = ($signed({1'b0, s2_ax_q}) >= s2_rm1_q) ||
                ($signed({1'b0, s2_ay_q}) >= s2_rm2_q);
    // edge signs reduce to R1*R2 +- R2*dx +- R1*dy
    po_c      = RHW'(s2_rp1_q) * RHW'(s2_rp2_q);
    ao_c      = RHW'(s2_rp2_q) * RHW'(s2_dx_q);
    bo_c      = RHW'(s2_rp1_q) * RHW'(s2_dy_q);
    pi_c      = RHW'(s2_rm1_q) * RHW'(s2_rm2_q);
    ai_c      = RHW'(s2_rm2_q) * RHW'(s2_dx_q);
    bi_c      = RHW'(s2_rm1_q) * RHW'(s2_dy_q);
    // split each ellipse term in halves to keep the multipliers narrow
    for (int k = 0; k < 3; k++) begin
      ll_c[k] = PW'(s2_ep_q[k][W-1:0]) * PW'(s2_ep_q[k][W-1:0]);
      hl_c[k] = (PW-1)'(s2_ep_q[k][EW-1:W]) * (PW-1)'(s2_ep_q[k][W-1:0]);
      hh_c[k] = (PW-2)'(s2_ep_q[k][EW-1:W]) * (PW-2)'(s2_ep_q[k][EW-1:W]);
    end
  end

  logic        [PW:0]    s3_dist2_q;
  logic        [PW-1:0]  s3_cp2_q;
  logic        [PW-3:0]  s3_cm2_q;
  logic                  s3_rm1_le0_q, s3_box_hit_q, s3_box_frm_q;
  logic signed [RHW-1:0] s3_po_q, s3_ao_q, s3_bo_q, s3_pi_q, s3_ai_q, s3_bi_q;
  logic        [PW-1:0]  s3_ll_q [3];
  logic        [PW-2:0]  s3_hl_q [3];
  logic        [PW-3:0]  s3_hh_q [3];
  logic        [2:0]     s3_kind_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[3]) begin
      s3_dist2_q   <= dist2_c;
      s3_cp2_q     <= cp2_c;
      s3_cm2_q     <= cm2_c;
      s3_rm1_le0_q <= s2_rm1_le0_q;
      s3_box_hit_q <= box_hit_c;
      s3_box_frm_q <= box_frm_c;
      s3_po_q      <= po_c;
      s3_ao_q      <= ao_c;
      s3_bo_q      <= bo_c;
      s3_pi_q      <= pi_c;
      s3_ai_q      <= ai_c;
      s3_bi_q      <= bi_c;
      s3_ll_q      <= ll_c;
      s3_hl_q      <= hl_c;
      s3_hh_q      <= hh_c;
      s3_kind_q    <= s2_kind_q;
    end
  end

  // ---------------- stage 4: circle and rhombus decisions, ellipse squares ----------------
  logic signed [RSW-1:0] ro_c [4];
  logic signed [RSW-1:0] ri_c [4];
  logic                  cir_hit_c, cir_frm_c, rho_hit_c, rho_frm_c;
  logic        [QW-1:0]  sq_c [3];

  always_comb begin
    cir_hit_c = s3_dist2_q < (PW+1)'(s3_cp2_q);
    cir_frm_c = s3_rm1_le0_q || (s3_dist2_q >= (PW+1)'(s3_cm2_q));
    ro_c[0]   = RSW'(s3_po_q) - RSW'(s3_ao_q) + RSW'(s3_bo_q);
    ro_c[1]   = RSW'(s3_po_q) - RSW'(s3_ao_q) - RSW'(s3_bo_q);
    ro_c[2]   = RSW'(s3_po_q) + RSW'(s3_ao_q) - RSW'(s3_bo_q);
    ro_c[3]   = RSW'(s3_po_q) + RSW'(s3_ao_q) + RSW'(s3_bo_q);
    ri_c[0]   = RSW'(s3_pi_q) - RSW'(s3_ai_q) + RSW'(s3_bi_q);
    ri_c[1]   = RSW'(s3_pi_q) - RSW'(s3_ai_q) - RSW'(s3_bi_q);
    ri_c[2]   = RSW'(s3_pi_q) + RSW'(s3_ai_q) - RSW'(s3_bi_q);
    ri_c[3]   = RSW'(s3_pi_q) + RSW'(s3_ai_q) + RSW'(s3_bi_q);
    rho_hit_c = 1'b1;
    rho_frm_c = 1'b0;
    for (int k = 0; k < 4; k++) begin
      rho_hit_c = rho_hit_c && (ro_c[k] > 0);
      rho_frm_c = rho_frm_c || (ri_c[k] < 0);
    end
    for (int k = 0; k < 3; k++) begin
      sq_c[k] = (QW'(s3_hh_q[k]) << PW) + (QW'(s3_hl_q[k]) << (W + 1)) + QW'(s3_ll_q[k]);
    end
  end

  logic          s4_cir_hit_q, s4_cir_frm_q, s4_rho_hit_q, s4_rho_frm_q;
  logic          s4_box_hit_q, s4_box_frm_q;
  logic [QW-1:0] s4_sq_q [3];
  logic [2:0]    s4_kind_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[4]) begin
      s4_cir_hit_q <= cir_hit_c;
      s4_cir_frm_q <= cir_frm_c;
      s4_rho_hit_q <= rho_hit_c;
      s4_rho_frm_q <= rho_frm_c;
      s4_box_hit_q <= s3_box_hit_q;
      s4_box_frm_q <= s3_box_frm_q;
      s4_sq_q      <= sq_c;
      s4_kind_q    <= s3_kind_q;
    end
  end

  // ---------------- stage 5: ellipse sums, shape select ----------------
  logic [QW:0]   l_c;
  logic [LW-1:0] k23_c, k17_c;
  logic          sel_hit_c, sel_frm_c, is_ell_c;

  always_comb begin
    l_c       = (QW+1)'(s4_sq_q[0]) + (QW+1)'(s4_sq_q[1]);
    k23_c     = (LW'(s4_sq_q[2]) << 4) + (LW'(s4_sq_q[2]) << 2) +
                (LW'(s4_sq_q[2]) << 1) + LW'(s4_sq_q[2]);
    k17_c     = (LW'(s4_sq_q[2]) << 4) + LW'(s4_sq_q[2]);
    sel_hit_c = 1'b0;
    sel_frm_c = 1'b0;
    is_ell_c  = 1'b0;
    case (s4_kind_q)
      nsht_pkg::SHAPE_CIRCLE: begin
        sel_hit_c = s4_cir_hit_q;
        sel_frm_c = s4_cir_frm_q;
      end
      nsht_pkg::SHAPE_ELLIPSE: begin
        is_ell_c = 1'b1;
      end
      nsht_pkg::SHAPE_BOX: begin
        sel_hit_c = s4_box_hit_q;
        sel_frm_c = s4_box_frm_q;
      end
      nsht_pkg::SHAPE_RHOMBUS: begin
        sel_hit_c = s4_rho_hit_q;
        sel_frm_c = s4_rho_frm_q;
      end
      nsht_pkg::SHAPE_NONE: begin
        sel_hit_c = 1'b0;
      end
      default: begin
        sel_hit_c = 1'b0;
      end
    endcase
  end

  logic [QW:0]   s5_l_q;
  logic [LW-1:0] s5_k23_q, s5_k17_q;
  logic          s5_hit_q, s5_frm_q, s5_ell_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[5]) begin
      s5_l_q   <= l_c;
      s5_k23_q <= k23_c;
      s5_k17_q <= k17_c;
      s5_hit_q <= sel_hit_c;
      s5_frm_q <= sel_frm_c;
      s5_ell_q <= is_ell_c;
    end
  end

  // ---------------- stage 6: ellipse compare, output register ----------------
  logic [LW-1:0] l20_c;
  logic          hit_c, frm_c;

  always_comb begin
    l20_c = (LW'(s5_l_q) << 4) + (LW'(s5_l_q) << 2);
    hit_c = s5_ell_q ? (l20_c < s5_k23_q) : s5_hit_q;
    frm_c = s5_ell_q ? (l20_c > s5_k17_q) : s5_frm_q;
  end

  logic s6_hit_q, s6_frm_q;

  always_ff @(posedge clk_i) begin
    if (stg_en[6]) begin
      s6_hit_q <= hit_c;
      s6_frm_q <= hit_c && frm_c && frame_en_i;
    end
  end

  assign rsp_o.valid    = vld_q[NST];
  assign rsp_o.hit      = s6_hit_q;
  assign rsp_o.on_frame = s6_frm_q;

endmodule

// ===== src/node_shape_hit_test.sv =====
// Node shape hit test: configuration registers and the hit test pipeline.
// Depends on nsht_pkg, nsht_if.sv and nsht_pipe.
//
// Usage:
//   req_i carries one request per node: query point, node center, half
//   extents, border and shape kind. rsp_o returns one result per request,
//   in order: hit, and on_frame (hit, inside the frame band and frame_enable set).
//   Both channels use valid/ready; a transfer happens when both are high.
//   The APB port holds min_band (address 0) and frame_enable (address 4);
//   write them only while no request is in flight.
// Timing:
//   One request is taken every cycle while the pipeline does not stall;
//   the rate is set by the six-stage pipeline, with at most one
//   multiplier of about 17x17 bits between any two register stages.
// Reset:
//   rst_ni clears all stage valid bits and loads min_band = 48 and
//   frame_enable = 1. There is no clearing pass.
// Stall:
//   When rsp_o.ready is low, the last stage holds its result; earlier
//   stages keep filling empty slots, and req_i.ready drops only once
//   every stage holds a request.
`timescale 1ns / 1ps

module node_shape_hit_test #(
  parameter int unsigned COORD_BITS = nsht_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  nsht_query_if.sink                         req_i,
  nsht_result_if.source                      rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nsht_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned MBW = COORD_BITS - 1;

  logic [MBW-1:0]     min_band_q, min_band_d;
  logic               frame_en_q, frame_en_d;
  logic               wr_en;
  nsht_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = nsht_pkg::reg_idx_e'(paddr[nsht_pkg::APB_ADDR_BITS-1]);

  always_comb begin
    min_band_d = min_band_q;
    frame_en_d = frame_en_q;
    if (wr_en) begin
      case (reg_idx)
        nsht_pkg::REG_MIN_BAND: min_band_d = pwdata[MBW-1:0];
        nsht_pkg::REG_FRAME_EN: frame_en_d = pwdata[0];
        default: begin
          min_band_d = min_band_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nsht_pkg::REG_MIN_BAND: prdata = 32'(min_band_q);
      nsht_pkg::REG_FRAME_EN: prdata = {31'b0, frame_en_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_band_q <= MBW'(nsht_pkg::MIN_BAND_RESET);
      frame_en_q <= nsht_pkg::FRAME_EN_RESET;
    end else begin
      min_band_q <= min_band_d;
      frame_en_q <= frame_en_d;
    end
  end

  nsht_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .min_band_i (min_band_q),
    .frame_en_i (frame_en_q),
    .req_i      (req_i),
    .rsp_o      (rsp_o)
  );

endmodule
